/* design/tsafp_pkg.sv */
// Shared types and constants for the transport stream adaptation field parser.
package tsafp_pkg;

    localparam logic [7:0] MAX_FIELD_LEN = 8'd183;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_FLAGS    = 4'd1,
        PH_PCR      = 4'd2,
        PH_OPCR     = 4'd3,
        PH_SPLICE   = 4'd4,
        PH_PRIVLEN  = 4'd5,
        PH_PRIVSKIP = 4'd6,
        PH_EXTLEN   = 4'd7,
        PH_EXTFLAGS = 4'd8,
        PH_LTW      = 4'd9,
        PH_PWR      = 4'd10,
        PH_SEAM     = 4'd11,
        PH_EXTSKIP  = 4'd12,
        PH_STUFF    = 4'd13,
        PH_ERR      = 4'd15
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       field_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  field_length;
        logic [7:0]  flag_bits;
        logic [41:0] pcr_value;
        logic [41:0] opcr_value;
        logic [7:0]  splice_cdn;
        logic [7:0]  private_data_length;
        logic [7:0]  extension_length;
        logic [2:0]  extension_flags;
        logic [15:0] ltw_word;
        logic [21:0] pw_rate;
        logic [3:0]  splice_kind;
        logic [32:0] next_au_dts;
    } out_item_t;

endpackage

/* design/tsafp_if.sv */
// Valid/ready channel interfaces for input bytes and parsed results.
interface tsafp_in_if;
    logic                 valid;
    logic                 ready;
    tsafp_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsafp_out_if;
    logic                 valid;
    logic                 ready;
    tsafp_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/tsafp_in_stage.sv */
// Input register: holds one byte transfer until the parser takes it.
module tsafp_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    tsafp_in_if.sink            stream,
    input  logic                can_take,
    output logic                item_vld,
    output tsafp_pkg::in_item_t item
);

    logic                vld_reg;
    logic                vld_next;
    tsafp_pkg::in_item_t item_reg;
    logic                take;

    assign take         = vld_reg && can_take;
    assign stream.ready = !vld_reg || take;
    assign vld_next     = (stream.valid && stream.ready) ? 1'b1 : (take ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            item_reg <= stream.data;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

/* design/tsafp_core.sv */
// Parse state machine: decodes one adaptation field byte per step.
module tsafp_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_vld,
    input  tsafp_pkg::in_item_t  item,
    input  logic                 can_take,
    output logic                 res_vld,
    output tsafp_pkg::out_item_t res
);

    localparam tsafp_pkg::phase_t TOP_PHASE [5] = '{tsafp_pkg::PH_PCR, tsafp_pkg::PH_OPCR,
        tsafp_pkg::PH_SPLICE, tsafp_pkg::PH_PRIVLEN, tsafp_pkg::PH_EXTLEN};
    localparam logic [2:0] TOP_BIT [5]  = '{3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
    localparam logic [7:0] TOP_NEED [5] = '{8'd6, 8'd6, 8'd1, 8'd1, 8'd2};
    localparam tsafp_pkg::phase_t EXT_PHASE [3] = '{tsafp_pkg::PH_LTW, tsafp_pkg::PH_PWR,
        tsafp_pkg::PH_SEAM};
    localparam logic [1:0] EXT_BIT [3]  = '{2'd2, 2'd1, 2'd0};
    localparam logic [7:0] EXT_NEED [3] = '{8'd2, 8'd3, 8'd5};

    // first present sub-field at or after position from, or stuffing; error if too few bytes remain for it
    function automatic tsafp_pkg::phase_t next_top(input logic [2:0] from,
                                                   input logic [7:0] flags,
                                                   input logic [7:0] left);
        tsafp_pkg::phase_t r;
        logic              hit;
        r   = tsafp_pkg::PH_STUFF;
        hit = 1'b0;
        for (int i = 0; i < 5; i++)
        begin
            if (!hit && (3'(i) >= from) && flags[TOP_BIT[i]])
            begin
                hit = 1'b1;
                r   = (left < TOP_NEED[i]) ? tsafp_pkg::PH_ERR : TOP_PHASE[i];
            end
        end
        return r;
    endfunction

    function automatic tsafp_pkg::phase_t next_ext(input logic [1:0] from,
                                                   input logic [2:0] eflags,
                                                   input logic [7:0] left);
        tsafp_pkg::phase_t r;
        logic              hit;
        r   = (left != 8'd0) ? tsafp_pkg::PH_EXTSKIP : tsafp_pkg::PH_STUFF;
        hit = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (!hit && (2'(i) >= from) && eflags[EXT_BIT[i]])
            begin
                hit = 1'b1;
                r   = (left < EXT_NEED[i]) ? tsafp_pkg::PH_ERR : EXT_PHASE[i];
            end
        end
        return r;
    endfunction

    // PCR bytes: 33-bit base, 6 reserved bits, 9-bit extension
    function automatic logic [41:0] clock_byte(input logic [41:0] acc,
                                               input logic [2:0]  idx,
                                               input logic [7:0]  b);
        logic [41:0] r;
        if (idx < 3'd4)
        begin
            r = {acc[33:0], b};
        end
        else if (idx == 3'd4)
        begin
            r = {acc[31:0], b[7], b[0], 8'd0};
        end
        else
        begin
            r = acc | {34'd0, b};
        end
        return r;
    endfunction

    tsafp_pkg::phase_t phase_reg, phase_next, nxt;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  ext_left_reg, ext_left_next;
    logic [2:0]  sub_idx_reg, sub_idx_next;
    logic [7:0]  skip_cnt_reg, skip_cnt_next;

    logic [7:0]  length_reg, length_next;
    logic [7:0]  flags_reg, flags_next;
    logic [41:0] pcr_reg, pcr_next;
    logic [41:0] opcr_reg, opcr_next;
    logic [7:0]  splice_cd_reg, splice_cd_next;
    logic [7:0]  priv_len_reg, priv_len_next;
    logic [7:0]  ext_len_reg, ext_len_next;
    logic [2:0]  ext_flags_reg, ext_flags_next;
    logic [15:0] ltw_reg, ltw_next;
    logic [21:0] rate_reg, rate_next;
    logic [3:0]  splice_kind_reg, splice_kind_next;
    logic [32:0] dts_reg, dts_next;

    logic        step;
    logic        active;
    logic        bad_len;
    logic        err;
    logic        done;
    logic [7:0]  b;
    logic [7:0]  bl;
    logic [7:0]  el;

    assign step = item_vld && can_take;
    assign b    = item.data_byte;
    assign bl   = bytes_left_reg - 8'd1;
    assign el   = ext_left_reg - 8'd1;

    // next state and counters
    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        ext_left_next   = ext_left_reg;
        sub_idx_next    = sub_idx_reg;
        skip_cnt_next   = skip_cnt_reg;
        nxt             = tsafp_pkg::PH_ERR;
        active          = 1'b0;
        bad_len         = 1'b0;
        if (step)
        begin
            if (item.field_start)
            begin
                bytes_left_next = b;
                ext_left_next   = 8'd0;
                sub_idx_next    = 3'd0;
                skip_cnt_next   = 8'd0;
                if (b == 8'd0 || b > tsafp_pkg::MAX_FIELD_LEN)
                begin
                    bad_len    = 1'b1;
                    phase_next = tsafp_pkg::PH_IDLE;
                end
                else
                begin
                    phase_next = tsafp_pkg::PH_FLAGS;
                end
            end
            else if (phase_reg == tsafp_pkg::PH_IDLE || bytes_left_reg == 8'd0)
            begin
                phase_next = tsafp_pkg::PH_IDLE;
            end
            else
            begin
                active          = 1'b1;
                bytes_left_next = bl;
                unique case (phase_reg)
                    tsafp_pkg::PH_FLAGS:
                    begin
                        nxt = next_top(3'd0, b, bl);
                    end
                    tsafp_pkg::PH_PCR:
                    begin
                        nxt = (sub_idx_reg >= 3'd5) ? next_top(3'd1, flags_reg, bl)
                                                    : tsafp_pkg::PH_PCR;
                    end
                    tsafp_pkg::PH_OPCR:
                    begin
                        nxt = (sub_idx_reg >= 3'd5) ? next_top(3'd2, flags_reg, bl)
                                                    : tsafp_pkg::PH_OPCR;
                    end
                    tsafp_pkg::PH_SPLICE:
                    begin
                        nxt = next_top(3'd3, flags_reg, bl);
                    end
                    tsafp_pkg::PH_PRIVLEN:
                    begin
                        if (b > bl)
                        begin
                            nxt = tsafp_pkg::PH_ERR;
                        end
                        else
                        begin
                            skip_cnt_next = b;
                            nxt = (b != 8'd0) ? tsafp_pkg::PH_PRIVSKIP
                                              : next_top(3'd4, flags_reg, bl);
                        end
                    end
                    tsafp_pkg::PH_PRIVSKIP:
                    begin
                        skip_cnt_next = (skip_cnt_reg != 8'd0) ? skip_cnt_reg - 8'd1 : 8'd0;
                        nxt = (skip_cnt_next != 8'd0) ? tsafp_pkg::PH_PRIVSKIP
                                                      : next_top(3'd4, flags_reg, bl);
                    end
                    tsafp_pkg::PH_EXTLEN:
                    begin
                        if (b == 8'd0 || b > bl)
                        begin
                            nxt = tsafp_pkg::PH_ERR;
                        end
                        else
                        begin
                            ext_left_next = b;
                            nxt           = tsafp_pkg::PH_EXTFLAGS;
                        end
                    end
                    tsafp_pkg::PH_EXTFLAGS:
                    begin
                        ext_left_next = el;
                        nxt           = next_ext(2'd0, b[7:5], el);
                    end
                    tsafp_pkg::PH_LTW:
                    begin
                        ext_left_next = el;
                        nxt = (sub_idx_reg >= 3'd1) ? next_ext(2'd1, ext_flags_reg, el)
                                                    : tsafp_pkg::PH_LTW;
                    end
                    tsafp_pkg::PH_PWR:
                    begin
                        ext_left_next = el;
                        nxt = (sub_idx_reg >= 3'd2) ? next_ext(2'd2, ext_flags_reg, el)
                                                    : tsafp_pkg::PH_PWR;
                    end
                    tsafp_pkg::PH_SEAM:
                    begin
                        ext_left_next = el;
                        nxt = (sub_idx_reg >= 3'd4) ? next_ext(2'd3, ext_flags_reg, el)
                                                    : tsafp_pkg::PH_SEAM;
                    end
                    tsafp_pkg::PH_EXTSKIP:
                    begin
                        ext_left_next = (ext_left_reg != 8'd0) ? el : 8'd0;
                        nxt = (ext_left_next != 8'd0) ? tsafp_pkg::PH_EXTSKIP
                                                      : tsafp_pkg::PH_STUFF;
                    end
                    tsafp_pkg::PH_STUFF:
                    begin
                        nxt = tsafp_pkg::PH_STUFF;
                    end
                    default:
                    begin
                        nxt = tsafp_pkg::PH_ERR;
                    end
                endcase
                sub_idx_next = (nxt == phase_reg) ? sub_idx_reg + 3'd1 : 3'd0;
                if (nxt == tsafp_pkg::PH_ERR || bl == 8'd0)
                begin
                    phase_next = tsafp_pkg::PH_IDLE;
                end
                else
                begin
                    phase_next = nxt;
                end
            end
        end
    end

    assign err     = bad_len || (active && nxt == tsafp_pkg::PH_ERR);
    assign done    = active && nxt != tsafp_pkg::PH_ERR && bl == 8'd0;
    assign res_vld = err || done;

    // field capture and result
    always_comb
    begin
        length_next      = length_reg;
        flags_next       = flags_reg;
        pcr_next         = pcr_reg;
        opcr_next        = opcr_reg;
        splice_cd_next   = splice_cd_reg;
        priv_len_next    = priv_len_reg;
        ext_len_next     = ext_len_reg;
        ext_flags_next   = ext_flags_reg;
        ltw_next         = ltw_reg;
        rate_next        = rate_reg;
        splice_kind_next = splice_kind_reg;
        dts_next         = dts_reg;
        if (step && item.field_start)
        begin
            length_next      = b;
            flags_next       = 8'd0;
            pcr_next         = 42'd0;
            opcr_next        = 42'd0;
            splice_cd_next   = 8'd0;
            priv_len_next    = 8'd0;
            ext_len_next     = 8'd0;
            ext_flags_next   = 3'd0;
            ltw_next         = 16'd0;
            rate_next        = 22'd0;
            splice_kind_next = 4'd0;
            dts_next         = 33'd0;
        end
        else if (active)
        begin
            case (phase_reg)
                tsafp_pkg::PH_FLAGS:    flags_next     = b;
                tsafp_pkg::PH_PCR:      pcr_next       = clock_byte(pcr_reg, sub_idx_reg, b);
                tsafp_pkg::PH_OPCR:     opcr_next      = clock_byte(opcr_reg, sub_idx_reg, b);
                tsafp_pkg::PH_SPLICE:   splice_cd_next = b;
                tsafp_pkg::PH_PRIVLEN:  priv_len_next  = b;
                tsafp_pkg::PH_EXTLEN:   ext_len_next   = b;
                tsafp_pkg::PH_EXTFLAGS: ext_flags_next = b[7:5];
                tsafp_pkg::PH_LTW:      ltw_next       = {ltw_reg[7:0], b};
                tsafp_pkg::PH_PWR:
                begin
                    rate_next = (sub_idx_reg == 3'd0) ? {16'd0, b[5:0]} : {rate_reg[13:0], b};
                end
                tsafp_pkg::PH_SEAM:
                begin
                    if (sub_idx_reg == 3'd0)
                    begin
                        splice_kind_next = b[7:4];
                        dts_next         = {30'd0, b[3:1]};
                    end
                    else if (sub_idx_reg == 3'd1 || sub_idx_reg == 3'd3)
                    begin
                        dts_next = {dts_reg[24:0], b};
                    end
                    else
                    begin
                        dts_next = {dts_reg[25:0], b[7:1]};
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (err)
        begin
            res = '0;
        end
        else
        begin
            res.field_length        = length_next;
            res.flag_bits           = flags_next;
            res.pcr_value           = pcr_next;
            res.opcr_value          = opcr_next;
            res.splice_cdn          = splice_cd_next;
            res.private_data_length = priv_len_next;
            res.extension_length    = ext_len_next;
            res.extension_flags     = ext_flags_next;
            res.ltw_word            = ltw_next;
            res.pw_rate             = rate_next;
            res.splice_kind         = splice_kind_next;
            res.next_au_dts         = dts_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= tsafp_pkg::PH_IDLE;
            bytes_left_reg <= 8'd0;
            ext_left_reg   <= 8'd0;
            sub_idx_reg    <= 3'd0;
            skip_cnt_reg   <= 8'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            ext_left_reg   <= ext_left_next;
            sub_idx_reg    <= sub_idx_next;
            skip_cnt_reg   <= skip_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        length_reg      <= length_next;
        flags_reg       <= flags_next;
        pcr_reg         <= pcr_next;
        opcr_reg        <= opcr_next;
        splice_cd_reg   <= splice_cd_next;
        priv_len_reg    <= priv_len_next;
        ext_len_reg     <= ext_len_next;
        ext_flags_reg   <= ext_flags_next;
        ltw_reg         <= ltw_next;
        rate_reg        <= rate_next;
        splice_kind_reg <= splice_kind_next;
        dts_reg         <= dts_next;
    end

endmodule

/* design/tsafp_out_stage.sv */
// Result register: holds one parsed result until the sink takes the transfer.
module tsafp_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_vld,
    input  tsafp_pkg::out_item_t res,
    output logic                 can_take,
    tsafp_out_if.source          result
);

    logic                 vld_reg;
    logic                 vld_next;
    tsafp_pkg::out_item_t data_reg;

    assign can_take = !vld_reg || result.ready;
    assign vld_next = res_vld ? 1'b1 : ((vld_reg && result.ready) ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_vld)
        begin
            data_reg <= res;
        end
    end

    assign result.valid = vld_reg;
    assign result.data  = data_reg;

endmodule

/* design/ts_adaptation_field_parser_unit.sv */
// Top level of the MPEG-2 transport stream adaptation field parser.
// Bytes enter on stream; a byte with field_start set is the field length byte and begins a
// new field. A byte waits in the input register while the core decodes it, and the
// edge that retires it also loads any result into the result register, so result.valid
// rises on the edge that retires a field's last byte. With result.ready high one byte
// transfer is taken every cycle. One result comes out per field, on its last byte; a zero or
// over-183 length, or a sub-field that overruns the field or extension, gives an all-zero
// result at once and later bytes are dropped until the next start. A start during a field
// abandons it with no result. While a result waits with result.ready low the core holds its
// byte, and stream.ready drops once the input register is full, until the result is taken.
module ts_adaptation_field_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    tsafp_in_if.sink    stream,
    tsafp_out_if.source result
);

    logic                 can_take;
    logic                 item_vld;
    tsafp_pkg::in_item_t  item;
    logic                 res_vld;
    tsafp_pkg::out_item_t res;

    tsafp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .stream   (stream),
        .can_take (can_take),
        .item_vld (item_vld),
        .item     (item)
    );

    tsafp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_vld (item_vld),
        .item     (item),
        .can_take (can_take),
        .res_vld  (res_vld),
        .res      (res)
    );

    tsafp_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_vld  (res_vld),
        .res      (res),
        .can_take (can_take),
        .result   (result)
    );

endmodule

/* sim/tb.sv */
// Self-checking testbench for the transport stream adaptation field parser.
module tb;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ZERO
    } chk_t;

    typedef struct packed {
        logic [7:0] b;
        logic       st;
        chk_t       chk;
    } af_row_t;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 950;

    localparam af_row_t DIRECTED_ROWS [24] = '{
        '{8'h5A, 1'b0, CHK_NONE},
        '{8'h00, 1'b1, CHK_ZERO},
        '{8'hB8, 1'b1, CHK_ZERO},
        '{8'hFF, 1'b1, CHK_ZERO},
        '{8'h01, 1'b1, CHK_NONE},
        '{8'hFF, 1'b0, CHK_ZERO},
        '{8'h03, 1'b1, CHK_NONE},
        '{8'h01, 1'b0, CHK_NONE},
        '{8'h00, 1'b0, CHK_ZERO},
        '{8'h77, 1'b0, CHK_NONE},
        '{8'h05, 1'b1, CHK_NONE},
        '{8'h00, 1'b0, CHK_NONE},
        '{8'hAA, 1'b0, CHK_NONE},
        '{8'h02, 1'b1, CHK_NONE},
        '{8'h00, 1'b0, CHK_NONE},
        '{8'hFF, 1'b0, CHK_MODEL},
        '{8'h07, 1'b1, CHK_NONE},
        '{8'h10, 1'b0, CHK_NONE},
        '{8'hFF, 1'b0, CHK_NONE},
        '{8'hFF, 1'b0, CHK_NONE},
        '{8'hFF, 1'b0, CHK_NONE},
        '{8'hFF, 1'b0, CHK_NONE},
        '{8'hFF, 1'b0, CHK_NONE},
        '{8'hFF, 1'b0, CHK_MODEL}
    };

    localparam tsafp_pkg::phase_t TOP_PH [5] = '{tsafp_pkg::PH_PCR, tsafp_pkg::PH_OPCR,
        tsafp_pkg::PH_SPLICE, tsafp_pkg::PH_PRIVLEN, tsafp_pkg::PH_EXTLEN};
    localparam int TOP_NEED [5] = '{6, 6, 1, 1, 2};
    localparam tsafp_pkg::phase_t EXT_PH [3] = '{tsafp_pkg::PH_LTW, tsafp_pkg::PH_PWR,
        tsafp_pkg::PH_SEAM};
    localparam int EXT_NEED [3] = '{2, 3, 5};

    logic clk = 1'b0;
    logic rst_n;

    tsafp_in_if  stream ();
    tsafp_out_if result ();

    ts_adaptation_field_parser_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .result (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // parser shadow state
    tsafp_pkg::phase_t    ph;
    logic [7:0]           bytes_rem;
    logic [7:0]           ext_rem;
    logic [7:0]           skip_rem;
    int                   sub_pos;
    tsafp_pkg::out_item_t acc;

    tsafp_pkg::out_item_t parsed_fields_due [$];
    logic [7:0]           af_body [$];
    chk_t                 cur_chk;

    int cycle_cnt;
    int mismatches;
    int items_sent;
    int fields_started;
    int results_seen;
    int zero_results;
    int stall_cycles;
    bit calm;
    bit steady;
    bit long_hold_req;

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 60)
            $display("MISMATCH @%0d: %s", cycle_cnt, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task automatic check_result(input tsafp_pkg::out_item_t got,
                                input tsafp_pkg::out_item_t want);
        check_field("field_length", got.field_length, want.field_length);
        check_field("flag_bits", got.flag_bits, want.flag_bits);
        check_field("pcr_value", got.pcr_value, want.pcr_value);
        check_field("opcr_value", got.opcr_value, want.opcr_value);
        check_field("splice_cdn", got.splice_cdn, want.splice_cdn);
        check_field("private_data_length", got.private_data_length,
                    want.private_data_length);
        check_field("extension_length", got.extension_length, want.extension_length);
        check_field("extension_flags", got.extension_flags, want.extension_flags);
        check_field("ltw_word", got.ltw_word, want.ltw_word);
        check_field("pw_rate", got.pw_rate, want.pw_rate);
        check_field("splice_kind", got.splice_kind, want.splice_kind);
        check_field("next_au_dts", got.next_au_dts, want.next_au_dts);
    endtask

    function automatic void clear_parse();
        acc = '0;
        bytes_rem = '0;
        ext_rem = '0;
        skip_rem = '0;
        sub_pos = 0;
    endfunction

    function automatic tsafp_pkg::phase_t next_top(input int from);
        for (int i = from; i < 5; i++)
        begin
            if (acc.flag_bits[4 - i])
            begin
                if (bytes_rem < TOP_NEED[i])
                    return tsafp_pkg::PH_ERR;
                sub_pos = 0;
                return TOP_PH[i];
            end
        end
        return tsafp_pkg::PH_STUFF;
    endfunction

    function automatic tsafp_pkg::phase_t next_ext(input int from);
        for (int i = from; i < 3; i++)
        begin
            if (acc.extension_flags[2 - i])
            begin
                if (ext_rem < EXT_NEED[i])
                    return tsafp_pkg::PH_ERR;
                sub_pos = 0;
                return EXT_PH[i];
            end
        end
        return (ext_rem != 0) ? tsafp_pkg::PH_EXTSKIP : tsafp_pkg::PH_STUFF;
    endfunction

    // 33-bit base then 6 reserved bits and 9-bit extension, packed as base << 9 | ext
    function automatic logic [41:0] pcr_shift(input logic [41:0] v, input int idx,
                                              input logic [7:0] b);
        if (idx < 4)
            return {v[33:0], b};
        if (idx == 4)
            return {v[31:0], b[7], b[0], 8'h00};
        return v | {34'd0, b};
    endfunction

    task automatic parse_af_byte(input logic [7:0] b, input logic st,
                                 output bit done, output tsafp_pkg::out_item_t res);
        tsafp_pkg::phase_t nxt;
        done = 1'b0;
        res = '0;
        if (st)
        begin
            clear_parse();
            if (b == 8'd0 || b > tsafp_pkg::MAX_FIELD_LEN)
            begin
                ph = tsafp_pkg::PH_IDLE;
                done = 1'b1;
                return;
            end
            acc.field_length = b;
            bytes_rem = b;
            ph = tsafp_pkg::PH_FLAGS;
            return;
        end
        if (ph == tsafp_pkg::PH_IDLE || bytes_rem == 0)
        begin
            ph = tsafp_pkg::PH_IDLE;
            return;
        end
        bytes_rem--;
        nxt = tsafp_pkg::PH_ERR;
        case (ph)
            tsafp_pkg::PH_FLAGS:
            begin
                acc.flag_bits = b;
                nxt = next_top(0);
            end
            tsafp_pkg::PH_PCR:
            begin
                acc.pcr_value = pcr_shift(acc.pcr_value, sub_pos, b);
                sub_pos++;
                nxt = (sub_pos >= 6) ? next_top(1) : tsafp_pkg::PH_PCR;
            end
            tsafp_pkg::PH_OPCR:
            begin
                acc.opcr_value = pcr_shift(acc.opcr_value, sub_pos, b);
                sub_pos++;
                nxt = (sub_pos >= 6) ? next_top(2) : tsafp_pkg::PH_OPCR;
            end
            tsafp_pkg::PH_SPLICE:
            begin
                acc.splice_cdn = b;
                nxt = next_top(3);
            end
            tsafp_pkg::PH_PRIVLEN:
            begin
                acc.private_data_length = b;
                if (b <= bytes_rem)
                begin
                    skip_rem = b;
                    nxt = (b != 0) ? tsafp_pkg::PH_PRIVSKIP : next_top(4);
                end
            end
            tsafp_pkg::PH_PRIVSKIP:
            begin
                if (skip_rem != 0)
                    skip_rem--;
                nxt = (skip_rem != 0) ? tsafp_pkg::PH_PRIVSKIP : next_top(4);
            end
            tsafp_pkg::PH_EXTLEN:
            begin
                acc.extension_length = b;
                if (b != 0 && b <= bytes_rem)
                begin
                    ext_rem = b;
                    nxt = tsafp_pkg::PH_EXTFLAGS;
                end
            end
            tsafp_pkg::PH_EXTFLAGS:
            begin
                ext_rem--;
                acc.extension_flags = b[7:5];
                nxt = next_ext(0);
            end
            tsafp_pkg::PH_LTW:
            begin
                ext_rem--;
                acc.ltw_word = {acc.ltw_word[7:0], b};
                sub_pos++;
                nxt = (sub_pos >= 2) ? next_ext(1) : tsafp_pkg::PH_LTW;
            end
            tsafp_pkg::PH_PWR:
            begin
                ext_rem--;
                acc.pw_rate = (sub_pos == 0) ? {16'd0, b[5:0]} : {acc.pw_rate[13:0], b};
                sub_pos++;
                nxt = (sub_pos >= 3) ? next_ext(2) : tsafp_pkg::PH_PWR;
            end
            tsafp_pkg::PH_SEAM:
            begin
                ext_rem--;
                if (sub_pos == 0)
                begin
                    acc.splice_kind = b[7:4];
                    acc.next_au_dts = {30'd0, b[3:1]};
                end
                else if (sub_pos == 1 || sub_pos == 3)
                    acc.next_au_dts = {acc.next_au_dts[24:0], b};
                else
                    acc.next_au_dts = {acc.next_au_dts[25:0], b[7:1]};
                sub_pos++;
                nxt = (sub_pos >= 5) ? next_ext(3) : tsafp_pkg::PH_SEAM;
            end
            tsafp_pkg::PH_EXTSKIP:
            begin
                if (ext_rem != 0)
                    ext_rem--;
                nxt = (ext_rem != 0) ? tsafp_pkg::PH_EXTSKIP : tsafp_pkg::PH_STUFF;
            end
            tsafp_pkg::PH_STUFF:
                nxt = tsafp_pkg::PH_STUFF;
            default:
                nxt = tsafp_pkg::PH_ERR;
        endcase
        if (nxt == tsafp_pkg::PH_ERR)
        begin
            clear_parse();
            ph = tsafp_pkg::PH_IDLE;
            done = 1'b1;
            return;
        end
        ph = nxt;
        if (bytes_rem == 0)
        begin
            done = 1'b1;
            res = acc;
            clear_parse();
            ph = tsafp_pkg::PH_IDLE;
        end
    endtask

    always @(posedge clk)
    begin
        bit                   done;
        tsafp_pkg::out_item_t res;
        cycle_cnt++;
        if (result.valid === 1'b1 && result.ready)
        begin
            results_seen++;
            if (result.data.field_length == 8'd0)
                zero_results++;
            if (parsed_fields_due.size() == 0)
                note_mismatch("result transfer with nothing expected");
            else
                check_result(result.data, parsed_fields_due.pop_front());
        end
        if (stream.valid && !stream.ready)
            stall_cycles++;
        if (stream.valid && stream.ready)
        begin
            items_sent++;
            if (stream.data.field_start)
                fields_started++;
            parse_af_byte(stream.data.data_byte, stream.data.field_start, done, res);
            case (cur_chk)
                CHK_MODEL:
                    if (done)
                        parsed_fields_due.push_back(res);
                CHK_ZERO:
                    parsed_fields_due.push_back('0);
                default:
                    ;
            endcase
        end
    end

    initial
    begin
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                 parsed_fields_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = 299;
                result.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                hold_left = $urandom_range(0, 15);
                result.ready <= 1'b0;
            end
            else
                result.ready <= 1'b1;
        end
    end

    task automatic send(input logic [7:0] b, input logic st, input chk_t chk);
        if (!calm && !steady && $urandom_range(0, 11) == 0)
        begin
            stream.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        stream.valid <= 1'b1;
        stream.data <= '{data_byte: b, field_start: st};
        cur_chk <= chk;
        do
            @(posedge clk);
        while (!stream.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        stream.valid <= 1'b0;
        while (parsed_fields_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic build_field();
        logic [7:0] flags;
        logic [7:0] ext_bytes [$];
        int n;
        af_body.delete();
        flags = 8'($urandom_range(0, 255));
        af_body.push_back(flags);
        if (flags[4])
            repeat (6) af_body.push_back(8'($urandom_range(0, 255)));
        if (flags[3])
            repeat (6) af_body.push_back(8'($urandom_range(0, 255)));
        if (flags[2])
            af_body.push_back(8'($urandom_range(0, 255)));
        if (flags[1])
        begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 4);
            af_body.push_back(8'(n));
            repeat (n) af_body.push_back(8'($urandom_range(0, 255)));
        end
        if (flags[0])
        begin
            ext_bytes.push_back(8'($urandom_range(0, 255)));
            if (ext_bytes[0][7])
                repeat (2) ext_bytes.push_back(8'($urandom_range(0, 255)));
            if (ext_bytes[0][6])
                repeat (3) ext_bytes.push_back(8'($urandom_range(0, 255)));
            if (ext_bytes[0][5])
                repeat (5) ext_bytes.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 2)) ext_bytes.push_back(8'($urandom_range(0, 255)));
            af_body.push_back(8'(ext_bytes.size()));
            foreach (ext_bytes[i])
                af_body.push_back(ext_bytes[i]);
        end
        if ($urandom_range(0, 24) == 0)
        begin
            while (af_body.size() < tsafp_pkg::MAX_FIELD_LEN)
                af_body.push_back(8'hFF);
        end
        else
            repeat ($urandom_range(0, 3)) af_body.push_back(8'hFF);
    endtask

    initial
    begin
        int pick;
        int cut;
        bit hold_done;
        hold_done = 1'b0;
        rst_n = 1'b0;
        stream.valid = 1'b0;
        stream.data = '0;
        cur_chk = CHK_MODEL;
        ph = tsafp_pkg::PH_IDLE;
        clear_parse();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_ROWS[i])
            send(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].st, DIRECTED_ROWS[i].chk);
        wait_drained();

        while (items_sent < RANDOM_ITEMS)
        begin
            calm = (items_sent > 830);
            pick = $urandom_range(0, 99);
            if (!hold_done && items_sent > 300)
            begin
                // back-pressure: result side holds off while short fields keep coming
                hold_done = 1'b1;
                long_hold_req = 1'b1;
                steady = 1'b1;
                repeat (40)
                begin
                    send(8'h01, 1'b1, CHK_MODEL);
                    send(8'($urandom_range(0, 255)) & 8'hE0, 1'b0, CHK_MODEL);
                end
                steady = 1'b0;
            end
            else if (pick < 72)
            begin
                build_field();
                send(8'(af_body.size()), 1'b1, CHK_MODEL);
                foreach (af_body[i])
                    send(af_body[i], 1'b0, CHK_MODEL);
            end
            else if (pick < 82)
            begin
                build_field();
                cut = $urandom_range(0, af_body.size() - 1);
                send(8'(af_body.size()), 1'b1, CHK_MODEL);
                for (int i = 0; i < cut; i++)
                    send(af_body[i], 1'b0, CHK_MODEL);
            end
            else if (pick < 90)
            begin
                build_field();
                send(8'(af_body.size() + $urandom_range(0, 6) - 3), 1'b1, CHK_MODEL);
                foreach (af_body[i])
                    send(af_body[i], 1'b0, CHK_MODEL);
                repeat ($urandom_range(0, 3))
                    send(8'($urandom_range(0, 255)), 1'b0, CHK_MODEL);
            end
            else if (pick < 97)
            begin
                repeat ($urandom_range(1, 8))
                    send(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, CHK_MODEL);
            end
            else
                wait_drained();
        end

        stream.valid <= 1'b0;
        while (parsed_fields_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Run covered %0d bytes, %0d field starts, %0d results (%0d all-zero)",
                 items_sent, fields_started, results_seen, zero_results);
        $display("Input held off for %0d cycles under result back-pressure", stall_cycles);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
